// ===== rtl/csnd_pkg.sv =====
// ----------------------------------------------------------------------------
// csnd_pkg
// Shared types and constants for the cross-set nearest distance core.
// ----------------------------------------------------------------------------
package csnd_pkg;

  localparam int COORD_W = 20;
  localparam int SLOT_W  = 10;
  localparam int CFG_W   = 11;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int DIST_W  = 42;

  // input tdata layout, lowest bit first
  localparam int SLOT_LO = 0;
  localparam int X_LO    = SLOT_LO + SLOT_W;
  localparam int Y_LO    = X_LO + COORD_W;
  localparam int Z_LO    = Y_LO + COORD_W;
  localparam int SET_LO  = Z_LO + COORD_W;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 48;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [DIST_W-1:0] DIST_NONE = '1;

  typedef struct packed {
    logic                      query;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      set_id;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      set_id;
  } particle_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } scan_state_t;

endpackage

// ===== rtl/csnd_front.sv =====
// ----------------------------------------------------------------------------
// csnd_front
// Input stage: takes stream transfers, decodes them into items and drops
// loads aimed past the end of the store.
// ----------------------------------------------------------------------------
module csnd_front #(
  parameter int MAX_PARTICLES = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [csnd_pkg::IN_DATA_W-1:0]  in_data,
  input  logic                            in_kind,
  output logic                            push,
  output csnd_pkg::item_t                 push_item,
  input  logic                            q_full
);
  import csnd_pkg::*;

  logic  held;
  item_t item;
  logic  keep;
  logic  advance;

  assign keep      = item.query || (32'(item.slot) < 32'(MAX_PARTICLES));
  assign push      = held && keep && !q_full;
  assign advance   = !held || !keep || !q_full;
  assign in_ready  = advance;
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (advance) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      item.query  <= (in_kind == REQ_QUERY);
      item.slot   <= in_data[SLOT_LO +: SLOT_W];
      item.x      <= in_data[X_LO +: COORD_W];
      item.y      <= in_data[Y_LO +: COORD_W];
      item.z      <= in_data[Z_LO +: COORD_W];
      item.set_id <= in_data[SET_LO];
    end
  end

endmodule

// ===== rtl/csnd_queue.sv =====
// ----------------------------------------------------------------------------
// csnd_queue
// Short item queue between the front and the scan engine.
// ----------------------------------------------------------------------------
module csnd_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  csnd_pkg::item_t        push_item,
  output logic                   full,
  input  logic                   pop,
  output csnd_pkg::queue_head_t  head
);
  import csnd_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_pop;

  assign full       = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head.valid = (fill != '0);
  assign head.item  = slots[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (!push && do_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/csnd_back.sv =====
// ----------------------------------------------------------------------------
// csnd_back
// Scan engine: owns the particle store, applies loads and runs each query
// as a pipelined pass over the store, one entry per cycle.
// ----------------------------------------------------------------------------
module csnd_back #(
  parameter int MAX_PARTICLES = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  csnd_pkg::queue_head_t         head,
  output logic                          pop,
  input  logic [csnd_pkg::CFG_W-1:0]    num_particles,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [csnd_pkg::DIST_W-1:0]   res_dist,
  output logic                          res_found
);
  import csnd_pkg::*;

  localparam int AW = $clog2(MAX_PARTICLES);
  localparam int CW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

  particle_t store [MAX_PARTICLES];

  scan_state_t state;
  scan_state_t state_next;

  logic          issue;
  logic          res_load;
  logic          start;
  logic          write_en;
  logic [CW-1:0] idx;
  logic [CW-1:0] count;
  logic [CW-1:0] count_lim;
  particle_t     qry;

  // pipeline stages
  logic                     rd_valid;
  particle_t                rd_data;
  logic                     df_valid;
  logic                     df_skip;
  logic [DIFF_W-1:0]        ax;
  logic [DIFF_W-1:0]        ay;
  logic [DIFF_W-1:0]        az;
  logic                     sq_valid;
  logic                     sq_skip;
  logic [DIST_W-1:0]        sq_x;
  logic [DIST_W-1:0]        sq_y;
  logic [DIST_W-1:0]        sq_z;
  logic [DIST_W-1:0]        sum_sq;
  logic [DIST_W-1:0]        best;
  logic                     found;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] dz;

  assign count_lim = (CW'(num_particles) > CW'(MAX_PARTICLES)) ?
                     CW'(MAX_PARTICLES) : CW'(num_particles);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (head.valid && head.item.query) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx == count) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid && !df_valid && !sq_valid) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_valid || res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    start    = 1'b0;
    write_en = 1'b0;
    issue    = 1'b0;
    res_load = 1'b0;
    case (state)
      ST_IDLE: begin
        pop      = head.valid;
        start    = head.valid && head.item.query;
        write_en = head.valid && !head.item.query;
      end
      ST_SCAN:  issue = (idx != count);
      ST_DRAIN: ;
      ST_DONE:  res_load = !res_valid || res_ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // store write and read
  always_ff @(posedge clk) begin
    if (write_en) begin
      store[AW'(head.item.slot)] <= '{x: head.item.x, y: head.item.y,
                                      z: head.item.z, set_id: head.item.set_id};
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= store[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx   <= '0;
      count <= count_lim;
      qry   <= '{x: head.item.x, y: head.item.y,
                 z: head.item.z, set_id: head.item.set_id};
    end else if (issue) begin
      idx <= idx + 1'b1;
    end
  end

  // signed differences and their magnitudes
  assign dx = DIFF_W'(qry.x) - DIFF_W'(rd_data.x);
  assign dy = DIFF_W'(qry.y) - DIFF_W'(rd_data.y);
  assign dz = DIFF_W'(qry.z) - DIFF_W'(rd_data.z);

  always_ff @(posedge clk) begin
    ax      <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ay      <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    az      <= dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
    df_skip <= (rd_data.set_id == qry.set_id);
    sq_x    <= ax * ax;
    sq_y    <= ay * ay;
    sq_z    <= az * az;
    sq_skip <= df_skip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      df_valid <= 1'b0;
      sq_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
      df_valid <= rd_valid;
      sq_valid <= df_valid;
    end
  end

  // sum fits in the output width, so it never reaches the all-ones code
  assign sum_sq = sq_x + sq_y + sq_z;

  always_ff @(posedge clk) begin
    if (start) begin
      best  <= DIST_NONE;
      found <= 1'b0;
    end else if (sq_valid && !sq_skip && (sum_sq != '0) && (sum_sq < best)) begin
      best  <= sum_sq;
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_dist  <= best;
      res_found <= found;
    end
  end

endmodule

// ===== rtl/cross_set_nearest_distance_core.sv =====
// ----------------------------------------------------------------------------
// cross_set_nearest_distance_core
// Particle store with cross-set nearest squared distance queries.
//
// s_axis carries requests: tuser selects load (0) or query (1). A load
// writes one store entry and returns nothing; loads whose slot lies past
// the store are dropped. A query returns one m_axis transfer holding the
// smallest nonzero squared distance to any particle of the other set
// among the first num_particles entries, with tuser high if one existed
// and the min_dist_sq field all ones otherwise.
// cfg writes num_particles; write it only while no request is in flight.
// A query scans min(num_particles, MAX_PARTICLES) entries: the store has
// one read port and the scan reads one entry per cycle through a 4-stage
// pipe. Requests queue in front of the scan engine, so s_axis keeps taking
// transfers while a query runs, until the queue fills. When m_axis
// stalls, the finished result is held and the next query waits to post.
// Reset empties the queue and clears num_particles; store contents are
// undefined until loaded.
// ----------------------------------------------------------------------------
module cross_set_nearest_distance_core #(
  parameter int MAX_PARTICLES = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // slot_index, pos_x, pos_y, pos_z, set_id, zero pad
  input  logic [csnd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // req_type
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // min_dist_sq, zero pad
  output logic [csnd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // found
  output logic                             m_axis_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [csnd_pkg::CFG_W-1:0]       cfg_data
);
  import csnd_pkg::*;

  logic              push;
  item_t             push_item;
  logic              q_full;
  logic              pop;
  queue_head_t       head;
  logic [CFG_W-1:0]  num_particles;
  logic [DIST_W-1:0] res_dist;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_particles <= '0;
    end else if (cfg_valid) begin
      num_particles <= cfg_data;
    end
  end

  csnd_front #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .in_kind   (s_axis_tuser),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  csnd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head)
  );

  csnd_back #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .num_particles (num_particles),
    .res_valid     (m_axis_tvalid),
    .res_ready     (m_axis_tready),
    .res_dist      (res_dist),
    .res_found     (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_DATA_W'(res_dist);

endmodule

// ===== verif/tb_cross_set_nearest_distance_core.sv =====
// ----------------------------------------------------------------------------
// tb_cross_set_nearest_distance_core
// Self-checking bench for the cross-set nearest distance core. Loads and
// queries are streamed in random bursts. Each accepted query is scored
// against an in-bench scan of a shadow particle store, and every result
// transfer is compared with the oldest pending score. The scan length is
// rewritten between phases while the core is quiet, from zero up to 160
// entries. The result side stalls on its own pattern and holds off
// once for a long stretch so that the request queue fills up.
// ----------------------------------------------------------------------------
module tb_cross_set_nearest_distance_core;
  import csnd_pkg::*;

  localparam int MAX_P       = 1024;
  localparam int SETTLE      = 64;
  localparam int HOLD_AFTER  = 40;
  localparam int HOLD_CYCLES = 600;
  localparam int LIMIT       = 1000000;
  localparam longint DIST_CAP = longint'(DIST_NONE);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    logic [DIST_W-1:0] dist_sq;
    logic              found;
  } nearest_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data = '0;

  cross_set_nearest_distance_core #(
    .MAX_PARTICLES(MAX_P)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  // stimulus side
  item_t     pending_reqs[$];
  particle_t plan_store[MAX_P];
  bit        plan_written[MAX_P];
  int        items_total = 0;
  int        settings_used = 0;

  // scoring side
  particle_t shadow_store[MAX_P];
  int        scan_count = 0;
  nearest_t  awaited_nearest[$];
  int        items_accepted = 0;
  int        loads_done = 0;
  int        queries_done = 0;
  int        results_seen = 0;
  int        matched = 0;
  int        unmatched = 0;
  int        mismatches = 0;

  function automatic longint sq_gap(coord_t a, coord_t b);
    longint d;
    d = longint'(a) - longint'(b);
    return d * d;
  endfunction

  function automatic nearest_t scan_nearest(item_t q);
    nearest_t r;
    longint   d;
    longint   best;
    bit       hit;
    int       lim;
    best = DIST_CAP;
    hit = 1'b0;
    lim = (scan_count > MAX_P) ? MAX_P : scan_count;
    for (int i = 0; i < lim; i++) begin
      if (shadow_store[i].set_id != q.set_id) begin
        d = sq_gap(q.x, shadow_store[i].x) + sq_gap(q.y, shadow_store[i].y) +
            sq_gap(q.z, shadow_store[i].z);
        if (d != 0) begin
          if (d >= DIST_CAP) begin
            d = DIST_CAP - 1;
          end
          if (!hit || d < best) begin
            best = d;
          end
          hit = 1'b1;
        end
      end
    end
    r.dist_sq = best[DIST_W-1:0];
    r.found = hit;
    return r;
  endfunction

  // request driver
  item_t on_bus;
  int    burst_left = 0;
  int    gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        items_accepted <= items_accepted + 1;
        if (on_bus.query == REQ_QUERY) begin
          awaited_nearest.push_back(scan_nearest(on_bus));
          queries_done++;
        end else begin
          shadow_store[on_bus.slot] = '{on_bus.x, on_bus.y, on_bus.z, on_bus.set_id};
          loads_done++;
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          on_bus = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {1'b0, on_bus.set_id, on_bus.z, on_bus.y, on_bus.x, on_bus.slot};
          s_axis_tuser <= on_bus.query;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side stall pattern, with one long hold-off
  int       hold_left = 0;
  int       mode_left = 0;
  bit       held_once = 1'b0;
  rx_mode_t rx_mode = RX_OPEN;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (!held_once && results_seen >= HOLD_AFTER) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN: begin
            m_axis_tready <= 1'b1;
          end
          RX_COIN: begin
            m_axis_tready <= 1'($urandom_range(0, 1));
          end
          default: begin
            m_axis_tready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  // result monitor
  nearest_t want;

  task automatic flag_mismatch(input string what, input nearest_t w);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %0d (%s): expected dist %0d found %0b, got dist %0d found %0b",
               mismatches, what, w.dist_sq, w.found, m_axis_tdata[DIST_W-1:0], m_axis_tuser);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (awaited_nearest.size() == 0) begin
        flag_mismatch("no query pending", '{DIST_NONE, 1'b0});
      end else begin
        want = awaited_nearest.pop_front();
        if (want.found) begin
          matched++;
        end else begin
          unmatched++;
        end
        if (m_axis_tdata[DIST_W-1:0] !== want.dist_sq || m_axis_tuser !== want.found) begin
          flag_mismatch("result transfer", want);
        end
      end
    end
  end

  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // stimulus helpers
  task automatic push_load(input int slot, input coord_t x, input coord_t y,
                           input coord_t z, input logic s);
    item_t it;
    it.query = REQ_LOAD;
    it.slot = SLOT_W'(slot);
    it.x = x;
    it.y = y;
    it.z = z;
    it.set_id = s;
    pending_reqs.push_back(it);
    plan_store[slot] = '{x, y, z, s};
    plan_written[slot] = 1'b1;
    items_total++;
  endtask

  task automatic push_query(input coord_t x, input coord_t y, input coord_t z,
                            input logic s);
    item_t it;
    it.query = REQ_QUERY;
    it.slot = SLOT_W'($urandom);
    it.x = x;
    it.y = y;
    it.z = z;
    it.set_id = s;
    pending_reqs.push_back(it);
    items_total++;
  endtask

  function automatic coord_t rand_coord();
    if ($urandom_range(0, 1) == 1) begin
      return coord_t'($urandom);
    end
    return coord_t'(int'($urandom_range(0, 8191)) - 4096);
  endfunction

  function automatic coord_t nudge(coord_t c);
    return coord_t'(int'(c) + int'($urandom_range(0, 64)) - 32);
  endfunction

  task automatic random_load(input int slot);
    push_load(slot, rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
  endtask

  task automatic random_query(input int lim);
    int        pick;
    particle_t p;
    pick = $urandom_range(0, 9);
    if (lim > 0 && pick < 3) begin
      // exact copy of a stored particle, either set
      p = plan_store[$urandom_range(0, lim - 1)];
      push_query(p.x, p.y, p.z, (pick == 0) ? p.set_id : ~p.set_id);
    end else if (lim > 0 && pick < 6) begin
      p = plan_store[$urandom_range(0, lim - 1)];
      push_query(nudge(p.x), nudge(p.y), nudge(p.z), 1'($urandom_range(0, 1)));
    end else begin
      push_query(rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic wait_quiet();
    while (items_accepted != items_total || awaited_nearest.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_count(input int n);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_data <= CFG_W'(n);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    scan_count = n;
    settings_used++;
  endtask

  task automatic run_phase(input int n, input int count);
    int lim;
    lim = (n > MAX_P) ? MAX_P : n;
    set_count(n);
    // every scanned entry must hold a loaded particle
    for (int i = 0; i < lim; i++) begin
      if (!plan_written[i]) begin
        random_load(i);
      end
    end
    repeat (count) begin
      if ($urandom_range(0, 99) < 45) begin
        if (lim > 0 && $urandom_range(0, 9) != 0) begin
          random_load($urandom_range(0, lim - 1));
        end else begin
          random_load($urandom_range(0, MAX_P - 1));
        end
      end else begin
        random_query(lim);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // scan length zero straight out of reset
    push_query(0, 0, 0, 1'b0);
    push_load(0, -524288, -524288, -524288, 1'b0);
    push_load(1, 524287, 524287, 524287, 1'b1);
    push_load(2, 0, 0, 0, 1'b0);
    push_load(3, 1, 0, 0, 1'b1);
    push_load(4, -1, -1, -1, 1'b1);
    push_load(5, 0, 0, 0, 1'b1);
    push_load(6, 1000, -2000, 3000, 1'b0);
    push_load(7, 524287, -524288, 0, 1'b1);

    set_count(2);
    // opposite corners give the largest distance
    push_query(524287, 524287, 524287, 1'b1);
    // only own set and a zero-distance entry
    push_query(-524288, -524288, -524288, 1'b1);

    set_count(8);
    push_query(0, 0, 0, 1'b0);
    push_query(0, 0, 0, 1'b1);
    push_query(-524288, 524287, -1, 1'b0);
    push_query(524287, -524288, 0, 1'b0);
    push_query(3, -7, 11, 1'b1);

    run_phase(1, 30);
    run_phase(16, 60);
    run_phase(5, 40);
    run_phase(64, 80);
    run_phase(3, 30);
    run_phase(160, 100);
    run_phase(32, 60);
    run_phase(0, 6);

    wait_quiet();
    $display("covered %0d loads and %0d queries (%0d with a match, %0d without)",
             loads_done, queries_done, matched, unmatched);
    $display("over %0d scan-length settings from 0 to 160, with one %0d-cycle result hold-off",
             settings_used, HOLD_CYCLES);
    if (mismatches == 0 && awaited_nearest.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
